### rtl/cog_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Collision occupancy grid package
// Field widths, action and command codes, register map and configuration type.
// ----------------------------------------------------------------------------
package cog_pkg;

   localparam int COORD_W     = 16;
   localparam int SIZE_W      = 15;
   localparam int MAP_W       = 7;
   localparam int TILE_W      = 9;
   localparam int NUM_W       = 17;
   localparam int STEP_W      = 5;
   localparam int ACT_W       = 2;
   localparam int CMD_W       = 3;
   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 32;
   localparam int QUEUE_DEPTH = 2;

   typedef logic [ACT_W-1:0] action_type;

   localparam action_type ACT_CLEAR = 2'd0;
   localparam action_type ACT_MARK  = 2'd1;
   localparam action_type ACT_QUERY = 2'd2;

   typedef logic [CMD_W-1:0] cmd_type;

   localparam cmd_type CMD_NOP     = 3'd0;
   localparam cmd_type CMD_CLEAR   = 3'd1;
   localparam cmd_type CMD_MARK    = 3'd2;
   localparam cmd_type CMD_QUERY   = 3'd3;
   localparam cmd_type CMD_OUTSIDE = 3'd4;

   typedef logic [1:0] reg_index_type;

   localparam reg_index_type REG_MAP_WIDTH   = 2'd0;
   localparam reg_index_type REG_MAP_HEIGHT  = 2'd1;
   localparam reg_index_type REG_TILE_WIDTH  = 2'd2;
   localparam reg_index_type REG_TILE_HEIGHT = 2'd3;

   typedef struct packed {
      logic [MAP_W-1:0]  map_width_tiles;
      logic [MAP_W-1:0]  map_height_tiles;
      logic [TILE_W-1:0] tile_width_px;
      logic [TILE_W-1:0] tile_height_px;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      map_width_tiles:  7'd64,
      map_height_tiles: 7'd64,
      tile_width_px:    9'd16,
      tile_height_px:   9'd16
   };

   function automatic int idx_w(input int n);
      return (n > 1) ? $clog2(n) : 1;
   endfunction

   function automatic int cnt_w(input int n);
      return $clog2(n + 1);
   endfunction

   function automatic int cmd_data_w(input int cols, input int rows);
      return CMD_W + 2 * idx_w(rows) + 2 * idx_w(cols);
   endfunction

endpackage

### rtl/cog_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tile span divider
// Restoring unsigned divider, one quotient bit per cycle; the quotient holds
// after done until the next start.
// ----------------------------------------------------------------------------
module cog_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [cog_pkg::NUM_W-1:0]  numer,
   input  logic [cog_pkg::TILE_W-1:0] denom,
   output logic                       done,
   output logic [cog_pkg::NUM_W-1:0]  quot
);
   import cog_pkg::*;

   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [TILE_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0]  quo_ff, quo_in;
   logic [TILE_W-1:0] den_ff, den_in;
   logic [TILE_W:0]   trial;
   logic [TILE_W:0]   diff;

   always_comb begin
      trial   = {rem_ff, quo_ff[NUM_W-1]};
      diff    = trial - {1'b0, den_ff};
      run_in  = run_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (start) begin
         run_in  = 1'b1;
         step_in = '0;
         rem_in  = '0;
         quo_in  = numer;
         den_in  = denom;
      end else if (run_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = diff[TILE_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[TILE_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(NUM_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = quo_ff;

endmodule

### rtl/cog_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Occupancy grid front end
// Accepts items, classifies them, turns mark rectangles into clipped tile
// spans and queues commands for the back end.
// ----------------------------------------------------------------------------
module cog_front #(
   parameter int MAX_MAP_COLS = 64,
   parameter int MAX_MAP_ROWS = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  cog_pkg::cfg_type            cfg,
   input  logic                        start,
   input  logic                        full,
   input  logic                        init_busy,
   output logic                        busy,
   input  cog_pkg::action_type         action,
   input  logic signed [cog_pkg::COORD_W-1:0] rect_left,
   input  logic signed [cog_pkg::COORD_W-1:0] rect_top,
   input  logic [cog_pkg::SIZE_W-1:0]  rect_width,
   input  logic [cog_pkg::SIZE_W-1:0]  rect_height,
   input  logic signed [cog_pkg::COORD_W-1:0] query_col,
   input  logic signed [cog_pkg::COORD_W-1:0] query_row,
   output logic                        push,
   output logic [cog_pkg::cmd_data_w(MAX_MAP_COLS, MAX_MAP_ROWS)-1:0] push_data
);
   import cog_pkg::*;

   localparam int COL_W  = idx_w(MAX_MAP_COLS);
   localparam int ROW_W  = idx_w(MAX_MAP_ROWS);
   localparam int CCNT_W = cnt_w(MAX_MAP_COLS);
   localparam int RCNT_W = cnt_w(MAX_MAP_ROWS);

   localparam logic [2:0] F_IDLE    = 3'd0;
   localparam logic [2:0] F_LO_GO   = 3'd1;
   localparam logic [2:0] F_LO_WAIT = 3'd2;
   localparam logic [2:0] F_HI_GO   = 3'd3;
   localparam logic [2:0] F_HI_WAIT = 3'd4;
   localparam logic [2:0] F_PUSH    = 3'd5;

   logic [2:0]        state_ff, state_in;
   logic [NUM_W-1:0]  lo_c_ff, lo_c_in, lo_r_ff, lo_r_in;
   logic [NUM_W-1:0]  hi_c_ff, hi_c_in, hi_r_ff, hi_r_in;
   logic              hi_neg_ff, hi_neg_in;
   logic [NUM_W-1:0]  qlo_c_ff, qlo_c_in, qlo_r_ff, qlo_r_in;

   logic [CCNT_W-1:0] cols;
   logic [RCNT_W-1:0] rows;
   logic [TILE_W-1:0] tw, th;
   logic [NUM_W:0]    hi_c_sum, hi_r_sum;
   logic [NUM_W-1:0]  lo_c_num, lo_r_num;
   logic              q_out;
   logic              accept;
   logic              div_start;
   logic [NUM_W-1:0]  num_c, num_r;
   logic              done_c, done_r;
   logic [NUM_W-1:0]  quot_c, quot_r;
   logic              span_empty;
   logic [COL_W-1:0]  c0, c1;
   logic [ROW_W-1:0]  r0, r1;

   assign cols = (32'(cfg.map_width_tiles) > MAX_MAP_COLS) ? CCNT_W'(MAX_MAP_COLS)
                                                          : CCNT_W'(cfg.map_width_tiles);
   assign rows = (32'(cfg.map_height_tiles) > MAX_MAP_ROWS) ? RCNT_W'(MAX_MAP_ROWS)
                                                           : RCNT_W'(cfg.map_height_tiles);
   assign tw = (cfg.tile_width_px == '0) ? TILE_W'(1) : cfg.tile_width_px;
   assign th = (cfg.tile_height_px == '0) ? TILE_W'(1) : cfg.tile_height_px;

   assign busy   = (state_ff != F_IDLE) | full | init_busy;
   assign accept = start & ~busy;

   // pixel left of the origin clips to tile 0
   assign lo_c_num = rect_left[COORD_W-1] ? '0 : NUM_W'(rect_left[COORD_W-2:0]);
   assign lo_r_num = rect_top[COORD_W-1]  ? '0 : NUM_W'(rect_top[COORD_W-2:0]);
   assign hi_c_sum = {{(NUM_W+1-COORD_W){rect_left[COORD_W-1]}}, rect_left}
                   + {{(NUM_W+1-SIZE_W){1'b0}}, rect_width} - (NUM_W+1)'(1);
   assign hi_r_sum = {{(NUM_W+1-COORD_W){rect_top[COORD_W-1]}}, rect_top}
                   + {{(NUM_W+1-SIZE_W){1'b0}}, rect_height} - (NUM_W+1)'(1);

   assign q_out = query_col[COORD_W-1] | query_row[COORD_W-1]
                | (32'(query_col[COORD_W-2:0]) >= 32'(cols))
                | (32'(query_row[COORD_W-2:0]) >= 32'(rows));

   assign div_start = (state_ff == F_LO_GO) | (state_ff == F_HI_GO);
   assign num_c     = (state_ff == F_HI_GO) ? hi_c_ff : lo_c_ff;
   assign num_r     = (state_ff == F_HI_GO) ? hi_r_ff : lo_r_ff;

   cog_div u_div_col (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (num_c),
      .denom (tw),
      .done  (done_c),
      .quot  (quot_c)
   );

   cog_div u_div_row (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (num_r),
      .denom (th),
      .done  (done_r),
      .quot  (quot_r)
   );

   assign span_empty = hi_neg_ff | (32'(qlo_c_ff) >= 32'(cols)) | (32'(qlo_r_ff) >= 32'(rows));
   assign c0 = COL_W'(qlo_c_ff);
   assign r0 = ROW_W'(qlo_r_ff);
   assign c1 = (32'(quot_c) >= 32'(cols)) ? COL_W'(cols - 1'b1) : COL_W'(quot_c);
   assign r1 = (32'(quot_r) >= 32'(rows)) ? ROW_W'(rows - 1'b1) : ROW_W'(quot_r);

   always_comb begin
      state_in  = state_ff;
      lo_c_in   = lo_c_ff;
      lo_r_in   = lo_r_ff;
      hi_c_in   = hi_c_ff;
      hi_r_in   = hi_r_ff;
      hi_neg_in = hi_neg_ff;
      qlo_c_in  = qlo_c_ff;
      qlo_r_in  = qlo_r_ff;
      push      = 1'b0;
      push_data = {CMD_NOP, {(2*ROW_W + 2*COL_W){1'b0}}};
      unique case (state_ff)
         F_IDLE: begin
            if (accept) begin
               unique case (action)
                  ACT_CLEAR: begin
                     push      = 1'b1;
                     push_data = {CMD_CLEAR, {(2*ROW_W + 2*COL_W){1'b0}}};
                  end
                  ACT_MARK: begin
                     if (rect_width == '0 || rect_height == '0) begin
                        push = 1'b1;
                     end else begin
                        lo_c_in   = lo_c_num;
                        lo_r_in   = lo_r_num;
                        hi_c_in   = hi_c_sum[NUM_W-1:0];
                        hi_r_in   = hi_r_sum[NUM_W-1:0];
                        hi_neg_in = hi_c_sum[NUM_W] | hi_r_sum[NUM_W];
                        state_in  = F_LO_GO;
                     end
                  end
                  ACT_QUERY: begin
                     push = 1'b1;
                     if (q_out) begin
                        push_data = {CMD_OUTSIDE, {(2*ROW_W + 2*COL_W){1'b0}}};
                     end else begin
                        push_data = {CMD_QUERY, ROW_W'(query_row[COORD_W-2:0]),
                                     {ROW_W{1'b0}}, COL_W'(query_col[COORD_W-2:0]),
                                     {COL_W{1'b0}}};
                     end
                  end
                  default: begin
                     push = 1'b1;
                  end
               endcase
            end
         end
         F_LO_GO: begin
            state_in = F_LO_WAIT;
         end
         F_LO_WAIT: begin
            if (done_c && done_r) begin
               qlo_c_in = quot_c;
               qlo_r_in = quot_r;
               state_in = F_HI_GO;
            end
         end
         F_HI_GO: begin
            state_in = F_HI_WAIT;
         end
         F_HI_WAIT: begin
            if (done_c && done_r) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (!full) begin
               push     = 1'b1;
               state_in = F_IDLE;
               if (!span_empty) begin
                  push_data = {CMD_MARK, r0, r1, c0, c1};
               end
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_c_ff   <= lo_c_in;
      lo_r_ff   <= lo_r_in;
      hi_c_ff   <= hi_c_in;
      hi_r_ff   <= hi_r_in;
      hi_neg_ff <= hi_neg_in;
      qlo_c_ff  <= qlo_c_in;
      qlo_r_ff  <= qlo_r_in;
   end

endmodule

### rtl/cog_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command queue
// Small register queue between the front and back ends.
// ----------------------------------------------------------------------------
module cog_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             pop_valid,
   output logic [WIDTH-1:0] pop_data
);
   import cog_pkg::*;

   localparam int PTR_W = idx_w(DEPTH);
   localparam int CNT_W = cnt_w(DEPTH);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/cog_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Occupancy grid back end
// Holds the tile map as one memory row per tile row, executes clear, mark and
// query commands and drives the result transfer.
// ----------------------------------------------------------------------------
module cog_back #(
   parameter int MAX_MAP_COLS = 64,
   parameter int MAX_MAP_ROWS = 64
) (
   input  logic clock,
   input  logic reset,
   input  logic pop_valid,
   input  logic [cog_pkg::cmd_data_w(MAX_MAP_COLS, MAX_MAP_ROWS)-1:0] pop_data,
   output logic pop,
   output logic init_busy,
   output logic rsp_valid,
   output logic rsp_blocked,
   output logic rsp_outside_map
);
   import cog_pkg::*;

   localparam int COL_W = idx_w(MAX_MAP_COLS);
   localparam int ROW_W = idx_w(MAX_MAP_ROWS);

   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(MAX_MAP_ROWS - 1);

   localparam logic [2:0] B_INIT  = 3'd0;
   localparam logic [2:0] B_IDLE  = 3'd1;
   localparam logic [2:0] B_CLEAR = 3'd2;
   localparam logic [2:0] B_MARK  = 3'd3;
   localparam logic [2:0] B_QUERY = 3'd4;

   logic [MAX_MAP_COLS-1:0] grid_mem [MAX_MAP_ROWS];
   logic [MAX_MAP_COLS-1:0] rd_data_ff;

   logic [2:0]       state_ff, state_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [ROW_W-1:0] last_ff, last_in;
   logic [COL_W-1:0] clo_ff, clo_in, chi_ff, chi_in;
   logic [COL_W-1:0] qcol_ff, qcol_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_blocked_ff, rsp_blocked_in;
   logic             rsp_outside_ff, rsp_outside_in;

   cmd_type          hd_kind;
   logic [ROW_W-1:0] hd_r0, hd_r1;
   logic [COL_W-1:0] hd_c0, hd_c1;

   logic                    wr_en;
   logic                    wr_bit;
   logic                    wr_all;
   logic [MAX_MAP_COLS-1:0] wr_mask;
   logic                    rd_en;

   assign {hd_kind, hd_r0, hd_r1, hd_c0, hd_c1} = pop_data;

   always_comb begin
      for (int i = 0; i < MAX_MAP_COLS; i++) begin
         wr_mask[i] = wr_all | ((COL_W'(i) >= clo_ff) && (COL_W'(i) <= chi_ff));
      end
   end

   always_comb begin
      state_in       = state_ff;
      row_in         = row_ff;
      last_in        = last_ff;
      clo_in         = clo_ff;
      chi_in         = chi_ff;
      qcol_in        = qcol_ff;
      rsp_valid_in   = 1'b0;
      rsp_blocked_in = 1'b0;
      rsp_outside_in = 1'b0;
      pop            = 1'b0;
      wr_en          = 1'b0;
      wr_bit         = 1'b0;
      wr_all         = 1'b0;
      rd_en          = 1'b0;
      unique case (state_ff) inside
         B_INIT, B_CLEAR: begin
            wr_en  = 1'b1;
            wr_all = 1'b1;
            if (row_ff == LAST_ROW) begin
               state_in     = B_IDLE;
               rsp_valid_in = (state_ff == B_CLEAR);
            end else begin
               row_in = row_ff + 1'b1;
            end
         end
         B_IDLE: begin
            if (pop_valid) begin
               pop = 1'b1;
               unique case (hd_kind)
                  CMD_CLEAR: begin
                     row_in   = '0;
                     state_in = B_CLEAR;
                  end
                  CMD_MARK: begin
                     row_in   = hd_r0;
                     last_in  = hd_r1;
                     clo_in   = hd_c0;
                     chi_in   = hd_c1;
                     state_in = B_MARK;
                  end
                  CMD_QUERY: begin
                     rd_en    = 1'b1;
                     qcol_in  = hd_c0;
                     state_in = B_QUERY;
                  end
                  CMD_OUTSIDE: begin
                     rsp_valid_in   = 1'b1;
                     rsp_blocked_in = 1'b1;
                     rsp_outside_in = 1'b1;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         B_MARK: begin
            wr_en  = 1'b1;
            wr_bit = 1'b1;
            if (row_ff == last_ff) begin
               state_in     = B_IDLE;
               rsp_valid_in = 1'b1;
            end else begin
               row_in = row_ff + 1'b1;
            end
         end
         B_QUERY: begin
            rsp_valid_in   = 1'b1;
            rsp_blocked_in = rd_data_ff[qcol_ff];
            state_in       = B_IDLE;
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         for (int i = 0; i < MAX_MAP_COLS; i++) begin
            if (wr_mask[i]) begin
               grid_mem[row_ff][i] <= wr_bit;
            end
         end
      end
      if (rd_en) begin
         rd_data_ff <= grid_mem[hd_r0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_INIT;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff        <= last_in;
      clo_ff         <= clo_in;
      chi_ff         <= chi_in;
      qcol_ff        <= qcol_in;
      rsp_blocked_ff <= rsp_blocked_in;
      rsp_outside_ff <= rsp_outside_in;
   end

   assign init_busy       = (state_ff == B_INIT);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_blocked     = rsp_blocked_ff;
   assign rsp_outside_map = rsp_outside_ff;

endmodule

### rtl/collision_occupancy_grid.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Collision occupancy grid
// One-bit blocked map of tiles: clear, mark pixel rectangle, query tile.
// ----------------------------------------------------------------------------
// Every accepted item gives exactly one result, one cycle on rsp_valid, in
// order; results cannot be held off. A query goes through a registered read
// of the map memory. A mark first goes through two 17-step serial divisions
// in the front end (start and end of the span, columns and rows in parallel),
// then the back end writes one memory row per covered tile row. A clear
// writes every memory row, one row per cycle. After reset a clearing pass
// over every memory row runs with busy high; configuration writes are taken
// during it. A two-entry command queue lets the front end take new items
// while the back end is still writing.
// ----------------------------------------------------------------------------
module collision_occupancy_grid #(
   parameter int MAX_MAP_COLS = 64,
   parameter int MAX_MAP_ROWS = 64
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [cog_pkg::CSR_ADDR_W-1:0]        paddr,
   input  logic [cog_pkg::CSR_DATA_W-1:0]        pwdata,
   output logic [cog_pkg::CSR_DATA_W-1:0]        prdata,
   output logic                                  pready,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [cog_pkg::ACT_W-1:0]             req_action,
   input  logic signed [cog_pkg::COORD_W-1:0]    req_rect_left,
   input  logic signed [cog_pkg::COORD_W-1:0]    req_rect_top,
   input  logic [cog_pkg::SIZE_W-1:0]            req_rect_width,
   input  logic [cog_pkg::SIZE_W-1:0]            req_rect_height,
   input  logic signed [cog_pkg::COORD_W-1:0]    req_query_col,
   input  logic signed [cog_pkg::COORD_W-1:0]    req_query_row,
   output logic                                  rsp_valid,
   output logic                                  rsp_blocked,
   output logic                                  rsp_outside_map
);
   import cog_pkg::*;

   localparam int DATA_W = cmd_data_w(MAX_MAP_COLS, MAX_MAP_ROWS);

   cfg_type       cfg_ff, cfg_in;
   logic          csr_wr;
   reg_index_type csr_index;

   logic              full;
   logic              push;
   logic [DATA_W-1:0] push_data;
   logic              pop;
   logic              pop_valid;
   logic [DATA_W-1:0] pop_data;
   logic              init_busy;

   assign pready    = 1'b1;
   assign csr_wr    = psel & penable & pwrite;
   assign csr_index = reg_index_type'(paddr[3:2]);

   always_comb begin
      cfg_in = cfg_ff;
      prdata = '0;
      unique case (csr_index)
         REG_MAP_WIDTH: begin
            prdata = CSR_DATA_W'(cfg_ff.map_width_tiles);
            if (csr_wr) cfg_in.map_width_tiles = pwdata[MAP_W-1:0];
         end
         REG_MAP_HEIGHT: begin
            prdata = CSR_DATA_W'(cfg_ff.map_height_tiles);
            if (csr_wr) cfg_in.map_height_tiles = pwdata[MAP_W-1:0];
         end
         REG_TILE_WIDTH: begin
            prdata = CSR_DATA_W'(cfg_ff.tile_width_px);
            if (csr_wr) cfg_in.tile_width_px = pwdata[TILE_W-1:0];
         end
         REG_TILE_HEIGHT: begin
            prdata = CSR_DATA_W'(cfg_ff.tile_height_px);
            if (csr_wr) cfg_in.tile_height_px = pwdata[TILE_W-1:0];
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   cog_front #(
      .MAX_MAP_COLS (MAX_MAP_COLS),
      .MAX_MAP_ROWS (MAX_MAP_ROWS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .start       (start),
      .full        (full),
      .init_busy   (init_busy),
      .busy        (busy),
      .action      (action_type'(req_action)),
      .rect_left   (req_rect_left),
      .rect_top    (req_rect_top),
      .rect_width  (req_rect_width),
      .rect_height (req_rect_height),
      .query_col   (req_query_col),
      .query_row   (req_query_row),
      .push        (push),
      .push_data   (push_data)
   );

   cog_fifo #(
      .WIDTH (DATA_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .pop_valid (pop_valid),
      .pop_data  (pop_data)
   );

   cog_back #(
      .MAX_MAP_COLS (MAX_MAP_COLS),
      .MAX_MAP_ROWS (MAX_MAP_ROWS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .pop_valid       (pop_valid),
      .pop_data        (pop_data),
      .pop             (pop),
      .init_busy       (init_busy),
      .rsp_valid       (rsp_valid),
      .rsp_blocked     (rsp_blocked),
      .rsp_outside_map (rsp_outside_map)
   );

endmodule

### rtl/cog_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Occupancy grid port checker
// Concurrent assertions on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
module cog_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic [cog_pkg::ACT_W-1:0]     req_action,
   input logic [cog_pkg::SIZE_W-1:0]    req_rect_width,
   input logic [cog_pkg::SIZE_W-1:0]    req_rect_height,
   input logic                          rsp_valid,
   input logic                          rsp_blocked,
   input logic                          rsp_outside_map
);
   import cog_pkg::*;

   // clearing pass after reset holds off new transfers
   a_busy_after_reset: assert property (@(posedge clock) reset |=> busy)
      else $error("busy low straight after reset");

   a_no_rsp_after_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result transfer straight after reset");

   a_outside_blocked: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_outside_map |-> rsp_blocked)
      else $error("tile outside map not reported blocked");

   // a non-empty mark goes through the span divider
   a_mark_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_action == ACT_MARK && req_rect_width != '0
      && req_rect_height != '0 |=> busy)
      else $error("busy low while dividing a mark span");

endmodule

bind collision_occupancy_grid cog_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_action      (req_action),
   .req_rect_width  (req_rect_width),
   .req_rect_height (req_rect_height),
   .rsp_valid       (rsp_valid),
   .rsp_blocked     (rsp_blocked),
   .rsp_outside_map (rsp_outside_map)
);
